[rtl/sparse_cosine_similarity_defines.svh]
// ----------------------------------------------------------------------------
// Sparse cosine similarity assertion macros
// Shared assertion forms for the checker of the similarity block.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COSINE_SIMILARITY_DEFINES_SVH
`define SPARSE_COSINE_SIMILARITY_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sparse cosine similarity check failed");

// Next-cycle implication, disabled while reset is high.
`define SCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sparse cosine similarity check failed");

`endif

[rtl/scs_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse cosine similarity package
// Widths, request kinds, sequencer states and the square-root link type.
// ----------------------------------------------------------------------------
package scs_pkg;

   localparam int DEF_MAX_REF_ELEMS = 1024;
   localparam int DEF_INDEX_BITS    = 32;

   localparam int FIDX_W = 32;
   localparam int VAL_W  = 16;
   localparam int SIM_W  = 16;
   localparam int DOT_W  = 48;
   localparam int NORM_W = 48;
   localparam int WIDE_W = 96;
   localparam int RAD_W  = 30;
   localparam int ROOT_W = 15;

   localparam logic [1:0] KIND_REF   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_START,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_LAUNCH,
      ST_SQRT,
      ST_OUT
   } state_type;

   // One link of the square-root cell chain.
   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
   } sqrt_link_type;

endpackage

[rtl/scs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square-root cell
// Decides one bit of an integer square root and passes the partial root on.
// ----------------------------------------------------------------------------
module scs_sqrt_cell
   import scs_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  sqrt_link_type link_in,
   output sqrt_link_type link_out
);

   sqrt_link_type     link_ff, link_in_c;
   logic [ROOT_W-1:0] trial;
   logic [RAD_W-1:0]  trial_sq;

   always_comb begin
      trial     = link_in.root | (ROOT_W'(1) << BIT);
      trial_sq  = RAD_W'(trial) * RAD_W'(trial);
      link_in_c = link_in;
      if (trial_sq <= link_in.rad) begin
         link_in_c.root = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_c.valid;
      end
      link_ff.rad  <= link_in_c.rad;
      link_ff.root <= link_in_c.root;
   end

   assign link_out = link_ff;

endmodule

[rtl/scs_sqrt_chain.sv]
// ----------------------------------------------------------------------------
// Square-root cell chain
// A row of cells, one root bit each, from the top bit down to bit zero.
// ----------------------------------------------------------------------------
module scs_sqrt_chain
   import scs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sqrt_link_type chain_in,
   output sqrt_link_type chain_out
);

   sqrt_link_type links [ROOT_W+1];

   assign links[0] = chain_in;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
      scs_sqrt_cell #(
         .BIT(ROOT_W - 1 - k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .link_in (links[k]),
         .link_out(links[k+1])
      );
   end

   assign chain_out = links[ROOT_W];

endmodule

[rtl/sparse_cosine_similarity.sv]
// Reference, clear and ignored requests are handled in the idle state, which they do not leave.
// A query element then holds the lookup state while the merge skips reference entries.
// A last query element then passes the start and output states; normalized mode can add
// 48 shift-add multiply steps, 30 divide steps and a 15-cell square-root chain.
// Reset is synchronous: counts, norms, flags and the sequencer clear, normalize sets.
// The reference memory is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
// Sparse cosine similarity
// Merge join of a query sparse vector against a stored reference vector.
// ----------------------------------------------------------------------------
module sparse_cosine_similarity
   import scs_pkg::*;
#(
   parameter int MAX_REF_ELEMS = DEF_MAX_REF_ELEMS,
   parameter int INDEX_BITS    = DEF_INDEX_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // feat_idx[31:0], value[47:32]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // similarity[15:0], dot_product[63:16],
                                    // ref_overflow[64], zero fill[71:65]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   localparam int ADDR_W  = (MAX_REF_ELEMS > 1) ? $clog2(MAX_REF_ELEMS) : 1;
   localparam int CNT_W   = $clog2(MAX_REF_ELEMS + 1);
   localparam int ENTRY_W = INDEX_BITS + VAL_W;
   localparam int STEP_W  = 6;

   state_type state_ff, state_in;

   logic [ENTRY_W-1:0] ref_mem [MAX_REF_ELEMS];
   logic [ENTRY_W-1:0] rd_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we;

   logic [CNT_W-1:0]      ref_count_ff, ref_count_in;
   logic [NORM_W-1:0]     ref_norm_ff, ref_norm_in;
   logic [NORM_W-1:0]     query_norm_ff, query_norm_in;
   logic [DOT_W-1:0]      dot_acc_ff, dot_acc_in;
   logic [CNT_W-1:0]      merge_ptr_ff, merge_ptr_in;
   logic                  ovf_ff, ovf_in;
   logic                  normalize_ff, normalize_in;
   logic [INDEX_BITS-1:0] q_fidx_ff, q_fidx_in;
   logic [VAL_W-1:0]      q_val_ff, q_val_in;
   logic                  q_last_ff, q_last_in;

   logic                neg_ff, neg_in;
   logic [DOT_W-1:0]    dot_out_ff, dot_out_in;
   logic                ovf_out_ff, ovf_out_in;
   logic [WIDE_W-1:0]   np_ff, np_in;
   logic [WIDE_W-1:0]   r_ff, r_in;
   logic [NORM_W-1:0]   qsh_ff, qsh_in;
   logic [NORM_W-1:0]   msh_ff, msh_in;
   logic [WIDE_W-1:0]   rnsh_ff, rnsh_in;
   logic [WIDE_W-1:0]   magsh_ff, magsh_in;
   logic [RAD_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SIM_W-1:0]    sim_ff, sim_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [71:0]         rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [63:0]           in_fidx64;
   logic [INDEX_BITS-1:0] in_fidx;
   logic signed [VAL_W-1:0] in_val;
   logic signed [31:0]    in_prod;
   logic [NORM_W:0]       qn_sum;
   logic                  full;
   logic [CNT_W-1:0]      ptr_plus;
   logic [INDEX_BITS-1:0] ref_idx;
   logic signed [VAL_W-1:0] ref_val;
   logic signed [31:0]    dprod;
   logic                  have, adv, hit;
   logic                  out_free;
   logic [DOT_W-1:0]      mag;
   logic [WIDE_W:0]       rem2;
   logic                  div_ge;
   sqrt_link_type         sqrt_in, sqrt_out;

   function automatic logic [SIM_W-1:0] sat16(input logic neg, input logic [DOT_W-1:0] m);
      logic [DOT_W-1:0] c;
      begin
         if (neg) begin
            c = (m > DOT_W'(32768)) ? DOT_W'(32768) : m;
            sat16 = SIM_W'(~c + DOT_W'(1));
         end else begin
            c = (m > DOT_W'(32767)) ? DOT_W'(32767) : m;
            sat16 = c[SIM_W-1:0];
         end
      end
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign in_fidx64  = {32'd0, req_tdata[FIDX_W-1:0]};
   assign in_fidx    = in_fidx64[INDEX_BITS-1:0];
   assign in_val     = $signed(req_tdata[FIDX_W+VAL_W-1:FIDX_W]);
   assign in_prod    = in_val * in_val;
   assign qn_sum     = {1'b0, query_norm_ff} + (NORM_W+1)'($unsigned(in_prod));
   assign full       = (ref_count_ff == CNT_W'(MAX_REF_ELEMS));
   assign mem_we     = accept && (req_tuser == KIND_REF) && !full;
   assign ptr_plus   = merge_ptr_ff + CNT_W'(1);
   assign ref_idx    = rd_ff[ENTRY_W-1:VAL_W];
   assign ref_val    = $signed(rd_ff[VAL_W-1:0]);
   assign dprod      = $signed(q_val_ff) * ref_val;
   assign have       = (merge_ptr_ff < ref_count_ff);
   assign adv        = have && (q_fidx_ff > ref_idx);
   assign hit        = have && (q_fidx_ff == ref_idx);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mag        = dot_acc_ff[DOT_W-1] ? (~dot_acc_ff + DOT_W'(1)) : dot_acc_ff;
   assign rem2       = {r_ff, 1'b0};
   assign div_ge     = (rem2 >= {1'b0, np_ff});
   assign rd_addr    = (state_ff == ST_LOOK) ? ptr_plus[ADDR_W-1:0]
                                             : merge_ptr_ff[ADDR_W-1:0];

   always_comb begin
      sqrt_in.valid = (state_ff == ST_LAUNCH);
      sqrt_in.rad   = quo_ff;
      sqrt_in.root  = '0;
   end

   scs_sqrt_chain u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .chain_in (sqrt_in),
      .chain_out(sqrt_out)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ref_mem[ref_count_ff[ADDR_W-1:0]] <= {in_fidx, in_val};
      end
      rd_ff <= ref_mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == KIND_QUERY) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!adv) begin
               state_in = q_last_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            if (!normalize_ff || query_norm_ff == '0 || ref_norm_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == STEP_W'(NORM_W - 1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = (r_ff >= np_ff) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(RAD_W - 1)) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_out.valid) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      ref_count_in  = ref_count_ff;
      ref_norm_in   = ref_norm_ff;
      query_norm_in = query_norm_ff;
      dot_acc_in    = dot_acc_ff;
      merge_ptr_in  = merge_ptr_ff;
      ovf_in        = ovf_ff;
      normalize_in  = csr_valid ? csr_data : normalize_ff;
      q_fidx_in     = q_fidx_ff;
      q_val_in      = q_val_ff;
      q_last_in     = q_last_ff;
      neg_in        = neg_ff;
      dot_out_in    = dot_out_ff;
      ovf_out_in    = ovf_out_ff;
      np_in         = np_ff;
      r_in          = r_ff;
      qsh_in        = qsh_ff;
      msh_in        = msh_ff;
      rnsh_in       = rnsh_ff;
      magsh_in      = magsh_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      sim_in        = sim_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  KIND_REF: begin
                     if (full) begin
                        ovf_in = 1'b1;
                     end else begin
                        ref_count_in = ref_count_ff + CNT_W'(1);
                        ref_norm_in  = ref_norm_ff + NORM_W'($unsigned(in_prod));
                     end
                  end
                  KIND_QUERY: begin
                     query_norm_in = qn_sum[NORM_W] ? '1 : qn_sum[NORM_W-1:0];
                     q_fidx_in     = in_fidx;
                     q_val_in      = in_val;
                     q_last_in     = req_tlast;
                  end
                  KIND_CLEAR: begin
                     ref_count_in  = '0;
                     ref_norm_in   = '0;
                     ovf_in        = 1'b0;
                     query_norm_in = '0;
                     dot_acc_in    = '0;
                     merge_ptr_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK: begin
            if (adv) begin
               merge_ptr_in = ptr_plus;
            end else if (hit) begin
               merge_ptr_in = ptr_plus;
               dot_acc_in   = dot_acc_ff + {{(DOT_W-32){dprod[31]}}, dprod};
            end
         end
         ST_START: begin
            neg_in        = dot_acc_ff[DOT_W-1];
            dot_out_in    = dot_acc_ff;
            ovf_out_in    = ovf_ff;
            dot_acc_in    = '0;
            query_norm_in = '0;
            merge_ptr_in  = '0;
            qsh_in        = query_norm_ff;
            rnsh_in       = {{(WIDE_W-NORM_W){1'b0}}, ref_norm_ff};
            msh_in        = mag;
            magsh_in      = {{(WIDE_W-DOT_W){1'b0}}, mag};
            np_in         = '0;
            r_in          = '0;
            step_in       = '0;
            if (!normalize_ff) begin
               sim_in = sat16(dot_acc_ff[DOT_W-1], mag >> 9);
            end else begin
               sim_in = '0;
            end
         end
         ST_MUL: begin
            if (qsh_ff[0]) begin
               np_in = np_ff + rnsh_ff;
            end
            if (msh_ff[0]) begin
               r_in = r_ff + magsh_ff;
            end
            qsh_in   = qsh_ff >> 1;
            msh_in   = msh_ff >> 1;
            rnsh_in  = rnsh_ff << 1;
            magsh_in = magsh_ff << 1;
            step_in  = step_ff + STEP_W'(1);
         end
         ST_CMP: begin
            // The root reaches the top of the range once the squared dot
            // is at least the norm product.
            sim_in  = sat16(neg_ff, DOT_W'(32768));
            quo_in  = '0;
            step_in = '0;
         end
         ST_DIV: begin
            if (div_ge) begin
               r_in = WIDE_W'(rem2 - {1'b0, np_ff});
            end else begin
               r_in = rem2[WIDE_W-1:0];
            end
            quo_in  = {quo_ff[RAD_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
         end
         ST_SQRT: begin
            if (sqrt_out.valid) begin
               sim_in = sat16(neg_ff, DOT_W'(sqrt_out.root));
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, ovf_out_ff, dot_out_ff, sim_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_count_ff  <= '0;
         ref_norm_ff   <= '0;
         query_norm_ff <= '0;
         dot_acc_ff    <= '0;
         merge_ptr_ff  <= '0;
         ovf_ff        <= 1'b0;
         normalize_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         ref_count_ff  <= ref_count_in;
         ref_norm_ff   <= ref_norm_in;
         query_norm_ff <= query_norm_in;
         dot_acc_ff    <= dot_acc_in;
         merge_ptr_ff  <= merge_ptr_in;
         ovf_ff        <= ovf_in;
         normalize_ff  <= normalize_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
      end
      q_fidx_ff   <= q_fidx_in;
      q_val_ff    <= q_val_in;
      q_last_ff   <= q_last_in;
      neg_ff      <= neg_in;
      dot_out_ff  <= dot_out_in;
      ovf_out_ff  <= ovf_out_in;
      np_ff       <= np_in;
      r_ff        <= r_in;
      qsh_ff      <= qsh_in;
      msh_ff      <= msh_in;
      rnsh_ff     <= rnsh_in;
      magsh_ff    <= magsh_in;
      quo_ff      <= quo_in;
      sim_ff      <= sim_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/scs_checker.sv]
// ----------------------------------------------------------------------------
// Sparse cosine similarity checker
// Port-level checks of request and response timing and response padding, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_cosine_similarity_defines.svh"

module scs_checker
   import scs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // A stalled response stays offered.
   `SCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // A query request is always followed by the merge lookup, with ready low.
   `SCS_ASSERT_NEXT(a_query_busy, clock, reset, req_tvalid && req_tready && req_tuser == KIND_QUERY, !req_tready)

   // Reference, clear and ignored requests leave ready high in the cycle after them.
   `SCS_ASSERT_NEXT(a_short_ready, clock, reset, req_tvalid && req_tready && req_tuser != KIND_QUERY, req_tready)

   // The response padding above the overflow flag is always zero.
   `SCS_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[71:65] == 7'd0)

endmodule

bind sparse_cosine_similarity scs_checker u_scs_checker (.*);

[dv/tb_sparse_cosine_similarity.sv]
// ----------------------------------------------------------------------------
// Sparse cosine similarity testbench
// Drives reference, query, clear and unused requests into the merge-join
// block with random gaps and stalls. A local predictor works out the
// expected similarity, dot product and overflow flag for every request that
// ends a query, and a checker compares them with each response.
// ----------------------------------------------------------------------------
module tb_sparse_cosine_similarity;
   timeunit 1ns;
   timeprecision 1ps;
   import scs_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int REF_DEPTH = DEF_MAX_REF_ELEMS;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 1200;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [SIM_W-1:0] sim;
      logic [DOT_W-1:0] dot;
      logic             ovf;
   } sim_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;

   // Predictor state.
   logic [FIDX_W-1:0] ref_index_mem [REF_DEPTH];
   logic signed [VAL_W-1:0] ref_value_mem [REF_DEPTH];
   int ref_len;
   longint unsigned ref_sq_sum;
   longint unsigned query_sq_sum;
   longint dot_sum;
   int merge_pos;
   bit ref_dropped;
   bit cosine_mode;

   sim_result_type expected_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   bit no_gaps = 1'b0;
   bit hold_request = 1'b0;

   sparse_cosine_similarity dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [SIM_W-1:0] clamp_q15(bit neg, longint unsigned mag);
      if (neg) begin
         if (mag > 64'd32768) mag = 64'd32768;
         return 16'(-mag);
      end
      if (mag > 64'd32767) mag = 64'd32767;
      return 16'(mag);
   endfunction

   // Largest root r with norms * r^2 <= (|dot| * 2^15)^2, found by bisection.
   function automatic logic [SIM_W-1:0] cosine_q15(bit neg, longint unsigned mag);
      logic [191:0] lhs, rhs, norms;
      longint unsigned lo, hi, mid;
      if (query_sq_sum == 0 || ref_sq_sum == 0) return '0;
      lo = 0;
      hi = 32768;
      rhs = 192'(mag << 15) * 192'(mag << 15);
      norms = 192'(query_sq_sum) * 192'(ref_sq_sum);
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         lhs = norms * 192'(mid * mid);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return clamp_q15(neg, lo);
   endfunction

   task automatic clear_predictor();
      ref_len = 0;
      ref_sq_sum = 0;
      query_sq_sum = 0;
      dot_sum = 0;
      merge_pos = 0;
      ref_dropped = 0;
   endtask

   task automatic predict_request(logic [1:0] kind, logic [31:0] fidx,
                                  logic signed [15:0] val, logic last);
      longint unsigned sq;
      longint unsigned norm_max;
      sim_result_type r;
      bit neg;
      longint unsigned mag;
      sq = longint'(val) * longint'(val);
      norm_max = (64'd1 << 48) - 1;
      case (kind)
         KIND_REF: begin
            if (ref_len < REF_DEPTH) begin
               ref_index_mem[ref_len] = fidx;
               ref_value_mem[ref_len] = val;
               ref_len++;
               ref_sq_sum += sq;
            end else begin
               ref_dropped = 1;
            end
         end
         KIND_CLEAR: clear_predictor();
         KIND_QUERY: begin
            query_sq_sum = (query_sq_sum > norm_max - sq) ? norm_max : query_sq_sum + sq;
            if (merge_pos < ref_len && fidx >= ref_index_mem[merge_pos]) begin
               while (merge_pos < ref_len && fidx > ref_index_mem[merge_pos]) merge_pos++;
               if (merge_pos < ref_len && fidx == ref_index_mem[merge_pos]) begin
                  dot_sum += longint'(val) * longint'(ref_value_mem[merge_pos]);
                  merge_pos++;
               end
            end
            if (last) begin
               neg = dot_sum < 0;
               mag = neg ? -dot_sum : dot_sum;
               r.sim = cosine_mode ? cosine_q15(neg, mag) : clamp_q15(neg, mag >> 9);
               r.dot = dot_sum[47:0];
               r.ovf = ref_dropped;
               expected_results = {expected_results, r};
               dot_sum = 0;
               query_sq_sum = 0;
               merge_pos = 0;
            end
         end
         default: ;
      endcase
   endtask

   // Leaves tvalid high on return; the gap before the next request lowers it.
   task automatic send_request(logic [1:0] kind, logic [31:0] fidx,
                               logic signed [15:0] val, logic last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {val, fidx};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_request(kind, fidx, val, last);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      cosine_mode = mode;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] any_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Ascending reference, then queries that hit some of its indices.
   task automatic send_vector_set(int ref_n, int queries);
      logic [31:0] idx, base;
      int qn;
      base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
      idx = base;
      send_request(KIND_CLEAR, $urandom, 16'($urandom), $urandom_range(0, 1));
      for (int i = 0; i < ref_n; i++) begin
         send_request(KIND_REF, idx, any_value(), $urandom_range(0, 1));
         idx += $urandom_range(1, 4);
      end
      for (int q = 0; q < queries; q++) begin
         qn = $urandom_range(1, 20);
         idx = base - $urandom_range(0, 2);
         for (int i = 0; i < qn; i++) begin
            send_request(KIND_QUERY, idx, any_value(), i == qn - 1);
            idx += $urandom_range(1, 5);
         end
      end
   endtask

   task automatic test_directed();
      send_request(KIND_QUERY, 32'd7, 16'sh1000, 1'b1);      // empty reference: zero norm
      send_request(KIND_REF, 32'd0, 16'sh7fff, 1'b1);
      send_request(KIND_REF, 32'd5, 16'sh8000, 1'b0);
      send_request(KIND_REF, 32'd9, 16'sh0001, 1'b0);
      send_request(KIND_REF, 32'hffff_ffff, 16'shffff, 1'b0);
      send_request(KIND_UNUSED, 32'd5, 16'sh7fff, 1'b1);
      send_request(KIND_QUERY, 32'd0, 16'sh8000, 1'b0);
      send_request(KIND_QUERY, 32'd3, 16'sh1234, 1'b0);
      send_request(KIND_QUERY, 32'd5, 16'sh8000, 1'b0);
      send_request(KIND_QUERY, 32'hffff_ffff, 16'sh8000, 1'b1);
      send_request(KIND_QUERY, 32'd0, 16'sh0000, 1'b1);     // zero query norm
      send_request(KIND_QUERY, 32'hffff_fffe, 16'sh7fff, 1'b0);
      send_request(KIND_QUERY, 32'd0, 16'sh7fff, 1'b1);     // out of order, reference passed
      send_request(KIND_QUERY, 32'd9, 16'sh7fff, 1'b0);
      send_request(KIND_QUERY, 32'd5, 16'sh7fff, 1'b1);
      send_request(KIND_QUERY, 32'd0, 16'sh7fff, 1'b0);
      send_request(KIND_CLEAR, 32'hffff_ffff, 16'shffff, 1'b1);  // drops the open query
      send_request(KIND_REF, 32'haaaa_5555, 16'sh4000, 1'b0);
      send_request(KIND_QUERY, 32'haaaa_5555, 16'sh4000, 1'b1);  // exact match, cosine one
      send_request(KIND_QUERY, 32'haaaa_5555, 16'shc000, 1'b1);  // minus one
   endtask

   task automatic test_raw_mode();
      write_mode(1'b0);
      send_request(KIND_CLEAR, 32'd0, 16'sh0, 1'b0);
      send_request(KIND_REF, 32'd1, 16'sh0010, 1'b0);
      send_request(KIND_REF, 32'd2, 16'sh8000, 1'b0);
      send_request(KIND_QUERY, 32'd1, 16'shfff0, 1'b1);     // small negative, truncation
      send_request(KIND_QUERY, 32'd2, 16'sh8000, 1'b1);     // positive saturation
      send_request(KIND_QUERY, 32'd2, 16'sh7fff, 1'b1);     // negative saturation
      send_request(KIND_QUERY, 32'd1, 16'sh0000, 1'b1);
      write_mode(1'b1);
   endtask

   task automatic test_ref_overflow();
      no_gaps = 1'b1;
      send_request(KIND_CLEAR, 32'd0, 16'sh0, 1'b0);
      for (int i = 0; i < REF_DEPTH + 6; i++)
         send_request(KIND_REF, 32'(i), any_value(), 1'b0);
      send_request(KIND_QUERY, 32'd0, 16'sh7fff, 1'b0);
      send_request(KIND_QUERY, 32'(REF_DEPTH - 1), any_value(), 1'b0);
      send_request(KIND_QUERY, 32'(REF_DEPTH + 2), any_value(), 1'b1);
      send_request(KIND_CLEAR, 32'd0, 16'sh0, 1'b0);
      send_request(KIND_REF, 32'd3, 16'sh0100, 1'b0);
      send_request(KIND_QUERY, 32'd3, 16'sh0100, 1'b1);     // flag cleared again
      no_gaps = 1'b0;
   endtask

   task automatic test_backpressure();
      send_request(KIND_CLEAR, 32'd0, 16'sh0, 1'b0);
      send_request(KIND_REF, 32'd4, 16'sh0800, 1'b0);
      hold_request = 1'b1;
      no_gaps = 1'b1;
      for (int i = 0; i < 10; i++)
         send_request(KIND_QUERY, 32'd4, any_value(), 1'b1);
      no_gaps = 1'b0;
   endtask

   task automatic test_random(int budget);
      int stop_at;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) write_mode($urandom_range(0, 1));
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8) begin
            send_vector_set($urandom_range(1, 24), $urandom_range(1, 3));
         end else begin
            // Noise: any kind, any index, any ordering.
            for (int i = 0; i < 8; i++)
               send_request(2'($urandom), $urandom, 16'($urandom), $urandom_range(0, 1));
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      cosine_mode = 1'b1;
      clear_predictor();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_raw_mode();
      test_ref_overflow();
      test_backpressure();
      write_mode(1'b1);
      test_random(150);
      write_mode(1'b0);
      test_random(50);
      wait_idle();
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // Result side: a random stall before each response, or one long hold.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 6);
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      sim_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h",
                     $realtime, rsp_tdata);
            mismatches++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_tdata[15:0] !== e.sim) begin
               $display("%0t: similarity expected %h actual %h",
                        $realtime, e.sim, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[63:16] !== e.dot) begin
               $display("%0t: dot product expected %h actual %h",
                        $realtime, e.dot, rsp_tdata[63:16]);
               mismatches++;
            end
            if (rsp_tdata[64] !== e.ovf) begin
               $display("%0t: overflow flag expected %b actual %b",
                        $realtime, e.ovf, rsp_tdata[64]);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles in which no request, response or register write moves.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
